>>> rtl/nnfs_pkg.sv
// nnfs_pkg: shared constants, types and helper functions for the
// nearest-neighbor fit scaler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nnfs_pkg;

	// frame store geometry
	localparam int MAX_WIDTH   = 64;
	localparam int MAX_HEIGHT  = 64;
	localparam int PIXEL_BITS  = 32;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

	// field widths
	localparam int COORD_BITS     = 8;
	localparam int SRC_BITS       = 7;
	localparam int BOX_BITS       = 8;
	localparam int MODE_BITS      = 2;
	localparam int SIZE_BITS      = 8;
	localparam int PIX_PORT_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 8;
	localparam int PROD_BITS      = BOX_BITS + SRC_BITS;

	// divider
	localparam int DIV_BITS     = 16;
	localparam int DIVISOR_BITS = 8;
	localparam int DIV_STEP     = 4;
	localparam int DIV_CYCLES   = DIV_BITS / DIV_STEP;
	localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_FIT    = 2'd0,
		MODE_HALF   = 2'd1,
		MODE_DOUBLE = 2'd2
	} mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SCALE_MODE = 3'd0,
		REG_SRC_WIDTH  = 3'd1,
		REG_SRC_HEIGHT = 3'd2,
		REG_BOX_WIDTH  = 3'd3,
		REG_BOX_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEO_SEL,
		ST_GEO_START,
		ST_GEO_DIV,
		ST_RD_DIV,
		ST_RD_OUT
	} back_state_t;

	typedef struct packed {
		logic [MODE_BITS-1:0] scale_mode;
		logic [SRC_BITS-1:0]  src_width;
		logic [SRC_BITS-1:0]  src_height;
		logic [BOX_BITS-1:0]  box_width;
		logic [BOX_BITS-1:0]  box_height;
	} cfg_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [COORD_BITS-1:0]    column;
		logic [COORD_BITS-1:0]    row;
		logic [PIX_PORT_BITS-1:0] pixel;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [PIX_PORT_BITS-1:0] pixel_out;
		logic [SIZE_BITS-1:0]     out_width;
		logic [SIZE_BITS-1:0]     out_height;
		logic                     in_range;
	} result_t;

	function automatic logic [SRC_BITS-1:0] eff_width(input logic [SRC_BITS-1:0] src);
		return (src > MAX_WIDTH) ? SRC_BITS'(MAX_WIDTH) : src;
	endfunction

	function automatic logic [SRC_BITS-1:0] eff_height(input logic [SRC_BITS-1:0] src);
		return (src > MAX_HEIGHT) ? SRC_BITS'(MAX_HEIGHT) : src;
	endfunction

	function automatic logic [ADDR_BITS-1:0] store_addr(
		input logic [DIV_BITS-1:0] x,
		input logic [DIV_BITS-1:0] y
	);
		return ADDR_BITS'(y) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(x);
	endfunction

	function automatic logic [SIZE_BITS-1:0] sat_size(input logic [DIV_BITS-1:0] q);
		return (q > DIV_BITS'((1 << SIZE_BITS) - 1)) ? '1 : SIZE_BITS'(q);
	endfunction

endpackage

`default_nettype wire

>>> rtl/nearest_neighbor_fit_scaler_unit.sv
// nearest_neighbor_fit_scaler_unit: top level with the register file,
// front queue and back end. Depends on nnfs_pkg, nnfs_front and nnfs_back.
//
//   channel   handshake             payload
//   input     push / full           cmd, column, row, pixel_in
//   result    empty / pop           pixel_out, out_width, out_height, in_range
//   config    cfg_we                cfg_index, cfg_data
//
// a write transfer is done as it is dequeued; an in-range read is dequeued,
// divided in the 4-bit-per-cycle dividers, issues the frame store read and loads
// the result register; an out-of-range read is dequeued and loads the result
// register. after any register write the back end redoes geometry (ratio select,
// then divider start and division, skipped when the output is empty) before it
// serves the next item. arst_n clears control state only: the frame store is not
// cleared. the input queue and the result register stall independently.
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_fit_scaler_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                cmd,
	input  logic [nnfs_pkg::COORD_BITS-1:0]     column,
	input  logic [nnfs_pkg::COORD_BITS-1:0]     row,
	input  logic [nnfs_pkg::PIX_PORT_BITS-1:0]  pixel_in,
	output logic                                empty,
	input  logic                                pop,
	output logic [nnfs_pkg::PIX_PORT_BITS-1:0]  pixel_out,
	output logic [nnfs_pkg::SIZE_BITS-1:0]      out_width,
	output logic [nnfs_pkg::SIZE_BITS-1:0]      out_height,
	output logic                                in_range,
	input  logic                                cfg_we,
	input  logic [nnfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [nnfs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import nnfs_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	q_head_t head;
	logic    head_pop;
	result_t res;
	logic    res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_mode <= MODE_FIT;
			cfg_q.src_width  <= SRC_BITS'(64);
			cfg_q.src_height <= SRC_BITS'(64);
			cfg_q.box_width  <= BOX_BITS'(64);
			cfg_q.box_height <= BOX_BITS'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_MODE: cfg_q.scale_mode <= cfg_data[MODE_BITS-1:0];
				REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[SRC_BITS-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[SRC_BITS-1:0];
				REG_BOX_WIDTH:  cfg_q.box_width  <= cfg_data[BOX_BITS-1:0];
				REG_BOX_HEIGHT: cfg_q.box_height <= cfg_data[BOX_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign item.cmd    = cmd_t'(cmd);
	assign item.column = column;
	assign item.row    = row;
	assign item.pixel  = pixel_in;

	nnfs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.head     (head),
		.head_pop (head_pop)
	);

	nnfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_we    (cfg_we),
		.head      (head),
		.head_pop  (head_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty      = !res_valid;
	assign pixel_out  = res.pixel_out;
	assign out_width  = res.out_width;
	assign out_height = res.out_height;
	assign in_range   = res.in_range;

endmodule

`default_nettype wire

>>> rtl/nnfs_ram.sv
// nnfs_ram: generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nnfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/nnfs_div.sv
// nnfs_div: iterative restoring divider, DIV_STEP quotient bits per cycle.
// Depends on nnfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnfs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [nnfs_pkg::DIV_BITS-1:0]     dividend,
	input  logic [nnfs_pkg::DIVISOR_BITS-1:0] divisor,
	output logic                              busy,
	output logic [nnfs_pkg::DIV_BITS-1:0]     quotient
);
	import nnfs_pkg::*;

	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0]     work_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] divisor_q;
	logic [DIV_BITS-1:0]     work_d;
	logic [DIVISOR_BITS-1:0] rem_d;

	// dividend shifts out of the top of work_q, quotient bits shift in at the bottom
	always_comb begin
		logic [DIVISOR_BITS:0]   t;
		logic [DIVISOR_BITS-1:0] r;
		logic [DIV_BITS-1:0]     w;
		r = rem_q;
		w = work_q;
		t = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r, w[DIV_BITS-1]};
			w = {w[DIV_BITS-2:0], 1'b0};
			if (t >= {1'b0, divisor_q}) begin
				t    = t - {1'b0, divisor_q};
				w[0] = 1'b1;
			end
			r = t[DIVISOR_BITS-1:0];
		end
		rem_d  = r;
		work_d = w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign busy     = busy_q;
	assign quotient = work_q;

endmodule

`default_nettype wire

>>> rtl/nnfs_front.sv
// nnfs_front: accepts input items, drops writes outside the source image
// and queues the rest for the back end. Depends on nnfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nnfs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  nnfs_pkg::cfg_t    cfg,
	input  logic              push,
	input  nnfs_pkg::item_t   item,
	output logic              full,
	output nnfs_pkg::q_head_t head,
	input  logic              head_pop
);
	import nnfs_pkg::*;

	item_t                ent_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic [SRC_BITS-1:0]  sw;
	logic [SRC_BITS-1:0]  sh;
	logic                 keep;
	logic                 enq;
	logic                 deq;

	assign sw   = eff_width(cfg.src_width);
	assign sh   = eff_height(cfg.src_height);
	assign keep = (item.cmd == CMD_READ) ||
	              ((item.column < COORD_BITS'(sw)) && (item.row < COORD_BITS'(sh)));
	assign full = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign enq  = push && !full && keep;
	assign deq  = head_pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			ent_q[wr_ptr_q] <= item;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = ent_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/nnfs_back.sv
// nnfs_back: geometry, source index division, frame store access and the
// result register. Depends on nnfs_pkg, nnfs_div and nnfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module nnfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  nnfs_pkg::cfg_t    cfg,
	input  logic              cfg_we,
	input  nnfs_pkg::q_head_t head,
	output logic              head_pop,
	output nnfs_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_pop
);
	import nnfs_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic                    geo_valid_q;
	logic                    res_valid_q;
	logic [BOX_BITS-1:0]     num_q;
	logic [SRC_BITS-1:0]     den_q;
	logic                    zero_q;
	logic [SIZE_BITS-1:0]    ow_q;
	logic [SIZE_BITS-1:0]    oh_q;
	logic                    inside_q;
	logic                    hit_q;
	result_t                 res_q;

	logic [SRC_BITS-1:0]     sw;
	logic [SRC_BITS-1:0]     sh;
	logic [PROD_BITS-1:0]    prod_w;
	logic [PROD_BITS-1:0]    prod_h;
	logic [BOX_BITS-1:0]     sel_num;
	logic [SRC_BITS-1:0]     sel_den;
	logic                    sel_zero;

	logic                    geo_sel_en;
	logic                    geo_load;
	logic                    rd_load;
	logic                    hit_load;
	logic                    res_load;
	logic                    read_inside;
	logic                    rd_hit;

	logic                    div_start;
	logic [DIV_BITS-1:0]     dividend_x;
	logic [DIV_BITS-1:0]     dividend_y;
	logic [DIVISOR_BITS-1:0] divisor;
	logic                    busy_x;
	logic                    busy_y;
	logic                    div_busy;
	logic [DIV_BITS-1:0]     quo_x;
	logic [DIV_BITS-1:0]     quo_y;

	logic                    ram_we;
	logic                    ram_re;
	logic [ADDR_BITS-1:0]    ram_addr;
	logic [PIXEL_BITS-1:0]   ram_rdata;

	assign sw = eff_width(cfg.src_width);
	assign sh = eff_height(cfg.src_height);

	// ratio selection; a tie in fit mode takes the width ratio
	always_comb begin
		prod_w  = PROD_BITS'(cfg.box_width) * PROD_BITS'(sh);
		prod_h  = PROD_BITS'(cfg.box_height) * PROD_BITS'(sw);
		sel_num = '0;
		sel_den = SRC_BITS'(1);
		unique case (cfg.scale_mode)
			MODE_HALF: begin
				sel_num = BOX_BITS'(1);
				sel_den = SRC_BITS'(2);
			end
			MODE_DOUBLE: begin
				sel_num = BOX_BITS'(2);
				sel_den = SRC_BITS'(1);
			end
			default: begin
				if ((sw != '0) && (sh != '0)) begin
					if (prod_w <= prod_h) begin
						sel_num = cfg.box_width;
						sel_den = sw;
					end else begin
						sel_num = cfg.box_height;
						sel_den = sh;
					end
				end
			end
		endcase
		sel_zero = (sw == '0) || (sh == '0) || (sel_num == '0);
	end

	assign read_inside = !zero_q && (head.item.column < ow_q) && (head.item.row < oh_q);
	assign rd_hit      = (quo_x < DIV_BITS'(MAX_WIDTH)) && (quo_y < DIV_BITS'(MAX_HEIGHT));
	assign div_busy    = busy_x || busy_y;

	always_comb begin
		if (state_q == ST_GEO_START) begin
			dividend_x = DIV_BITS'(sw) * DIV_BITS'(num_q);
			dividend_y = DIV_BITS'(sh) * DIV_BITS'(num_q);
			divisor    = DIVISOR_BITS'(den_q);
		end else begin
			dividend_x = DIV_BITS'(head.item.column) * DIV_BITS'(den_q);
			dividend_y = DIV_BITS'(head.item.row) * DIV_BITS'(den_q);
			divisor    = num_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		head_pop   = 1'b0;
		div_start  = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = store_addr(DIV_BITS'(head.item.column), DIV_BITS'(head.item.row));
		geo_sel_en = 1'b0;
		geo_load   = 1'b0;
		rd_load    = 1'b0;
		hit_load   = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!geo_valid_q) begin
					state_d = ST_GEO_SEL;
				end else if (head.valid) begin
					head_pop = 1'b1;
					if (head.item.cmd == CMD_WRITE) begin
						ram_we = 1'b1;
					end else begin
						rd_load = 1'b1;
						if (read_inside) begin
							div_start = 1'b1;
							state_d   = ST_RD_DIV;
						end else begin
							state_d = ST_RD_OUT;
						end
					end
				end
			end
			ST_GEO_SEL: begin
				geo_sel_en = 1'b1;
				state_d    = ST_GEO_START;
			end
			ST_GEO_START: begin
				if (zero_q) begin
					geo_load = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_GEO_DIV;
				end
			end
			ST_GEO_DIV: begin
				if (!div_busy) begin
					geo_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RD_DIV: begin
				if (!div_busy) begin
					ram_re   = rd_hit;
					ram_addr = store_addr(quo_x, quo_y);
					hit_load = 1'b1;
					state_d  = ST_RD_OUT;
				end
			end
			ST_RD_OUT: begin
				if (!res_valid_q || res_pop) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// a register write restarts any geometry pass in flight
		if (cfg_we && ((state_q == ST_GEO_SEL) || (state_q == ST_GEO_START) ||
		               (state_q == ST_GEO_DIV))) begin
			state_d = ST_GEO_SEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				geo_valid_q <= 1'b0;
			end else if (geo_load) begin
				geo_valid_q <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (geo_sel_en) begin
			num_q  <= sel_num;
			den_q  <= sel_den;
			zero_q <= sel_zero;
		end
		if (geo_load) begin
			ow_q <= zero_q ? '0 : sat_size(quo_x);
			oh_q <= zero_q ? '0 : sat_size(quo_y);
		end
		if (rd_load) begin
			inside_q <= read_inside;
			hit_q    <= 1'b0;
		end else if (hit_load) begin
			hit_q <= rd_hit;
		end
		if (res_load) begin
			res_q.pixel_out  <= hit_q ? PIX_PORT_BITS'(ram_rdata) : '0;
			res_q.out_width  <= ow_q;
			res_q.out_height <= oh_q;
			res_q.in_range   <= inside_q;
		end
	end

	nnfs_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend_x),
		.divisor  (divisor),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	nnfs_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend_y),
		.divisor  (divisor),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	nnfs_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (STORE_DEPTH)
	) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (PIXEL_BITS'(head.item.pixel)),
		.rdata (ram_rdata)
	);

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire
